### rtl/arpc_pkg.sv
// Shared definitions for the ARP cache table: operation and status codes,
// field widths and the structs that travel along the slot chain.
// No dependencies; every other file in rtl/ uses this package.
package arpc_pkg;

  localparam int ENTRIES_DEFAULT = 16;

  localparam int OP_W     = 3;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int STATUS_W = 2;
  localparam int LIFE_W   = 16;
  localparam int TIME_W   = 32;

  localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(300);

  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH  = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WRONG     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  // Search token that walks the slot chain one slot per cycle.
  typedef struct packed {
    logic             valid;
    logic [OP_W-1:0]  op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             found;
    logic             found_static;
    logic [MAC_W-1:0] found_mac;
    logic             free_found;
  } tok_t;

  // Slot write command broadcast by the commit logic.
  typedef struct packed {
    logic             en;
    logic             clear;
    logic             stat;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } wr_t;

endpackage

### rtl/arpc_cell.sv
// One slot of the ARP cache: holds its entry, updates the passing search
// token and applies broadcast writes addressed to it. Uses arpc_pkg.
module arpc_cell #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT,
  parameter int INDEX   = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [arpc_pkg::TIME_W-1:0]   now,
  input  logic [arpc_pkg::LIFE_W-1:0]   lifetime,
  input  arpc_pkg::tok_t                tok_in,
  input  logic [$clog2(ENTRIES)-1:0]    found_idx_in,
  input  logic [$clog2(ENTRIES)-1:0]    free_idx_in,
  output arpc_pkg::tok_t                tok_out,
  output logic [$clog2(ENTRIES)-1:0]    found_idx_out,
  output logic [$clog2(ENTRIES)-1:0]    free_idx_out,
  input  arpc_pkg::wr_t                 wr,
  input  logic [$clog2(ENTRIES)-1:0]    wr_idx
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic                         used;
  logic                         stat;
  logic [arpc_pkg::IP_W-1:0]    ip;
  logic [arpc_pkg::MAC_W-1:0]   mac;
  logic [arpc_pkg::TIME_W-1:0]  birth;

  logic [arpc_pkg::TIME_W-1:0]  age;
  logic                         valid_here;
  logic                         match;
  logic                         wr_here;
  arpc_pkg::tok_t               tok_next;
  logic [IDX_W-1:0]             found_idx_next;
  logic [IDX_W-1:0]             free_idx_next;

  assign age        = now - birth;
  assign valid_here = used && (stat || (age <= {{(arpc_pkg::TIME_W-arpc_pkg::LIFE_W){1'b0}},
                                                 lifetime}));
  assign match      = valid_here && (ip == tok_in.ip);
  assign wr_here    = wr.en && (wr_idx == MY_IDX);

  // The first valid match and the first free slot along the chain win.
  always_comb begin
    tok_next       = tok_in;
    found_idx_next = found_idx_in;
    free_idx_next  = free_idx_in;
    if (match && !tok_in.found) begin
      tok_next.found        = 1'b1;
      tok_next.found_static = stat;
      tok_next.found_mac    = mac;
      found_idx_next        = MY_IDX;
    end
    if (!valid_here && !tok_in.free_found) begin
      tok_next.free_found = 1'b1;
      free_idx_next       = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out       <= tok_next;
      found_idx_out <= found_idx_next;
      free_idx_out  <= free_idx_next;
      priority if (wr_here) begin
        used <= !wr.clear;
      end else if (tok_in.valid && tok_in.op == arpc_pkg::OP_FLUSH && used && !stat) begin
        used <= 1'b0;
      end else if (tok_in.valid && tok_in.op == arpc_pkg::OP_TICK && !valid_here) begin
        used <= 1'b0;
      end else begin
        used <= used;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here && !wr.clear) begin
      stat  <= wr.stat;
      ip    <= wr.ip;
      mac   <= wr.mac;
      birth <= now;
    end
  end

endmodule

### rtl/arp_cache_table.sv
// An accepted input beat passes the launch register, the slot chain, the pending
// register and the output register on its way to the result beat. The search token walks
// the slot chain one slot per cycle, and one operation is in flight at a time.
// Reset (rst, synchronous): all slots empty, seconds count zero, lifetime 300.
// The output register lets a result wait while the next beat is accepted.
// Uses arpc_pkg and arpc_cell.
module arp_cache_table #(
  parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input stream.
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [79:0]                  s_tdata,   // ip_addr[31:0], mac_addr[79:32]
  input  logic [arpc_pkg::OP_W-1:0]    s_tuser,   // operation[2:0]
  // Result stream.
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [55:0]                  m_tdata,   // hit[0], mac_out[48:1], status[50:49]
  // Lifetime register write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [arpc_pkg::LIFE_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);

  // Control state.
  logic                            busy;
  logic                            pend_valid;
  logic                            out_valid;
  logic [arpc_pkg::LIFE_W-1:0]     lifetime;
  logic [arpc_pkg::TIME_W-1:0]     now;

  // Payload registers.
  arpc_pkg::tok_t                  launch;
  arpc_pkg::tok_t                  pend;
  logic [IDX_W-1:0]                pend_found_idx;
  logic [IDX_W-1:0]                pend_free_idx;
  logic                            out_hit;
  logic [arpc_pkg::MAC_W-1:0]      out_mac;
  logic [arpc_pkg::STATUS_W-1:0]   out_status;

  // Chain wiring; element k feeds slot k.
  arpc_pkg::tok_t                  tok       [0:ENTRIES];
  logic [IDX_W-1:0]                found_idx [0:ENTRIES];
  logic [IDX_W-1:0]                free_idx  [0:ENTRIES];

  logic                            accept;
  logic                            commit;
  arpc_pkg::wr_t                   wr;
  logic [IDX_W-1:0]                wr_idx;
  logic                            res_hit;
  logic [arpc_pkg::MAC_W-1:0]      res_mac;
  logic [arpc_pkg::STATUS_W-1:0]   res_status;

  assign s_tready  = !busy;
  assign accept    = s_tvalid && !busy;
  assign cfg_ready = 1'b1;
  assign commit    = pend_valid && (!out_valid || m_tready);

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_status, out_mac, out_hit};

  // The launch register lets the seconds counter advance on a tick before the first
  // slot judges expiry against it.
  assign tok[0]       = launch;
  assign found_idx[0] = '0;
  assign free_idx[0]  = '0;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_slot
      arpc_cell #(
        .ENTRIES (ENTRIES),
        .INDEX   (g)
      ) u_slot (
        .clk           (clk),
        .rst           (rst),
        .now           (now),
        .lifetime      (lifetime),
        .tok_in        (tok[g]),
        .found_idx_in  (found_idx[g]),
        .free_idx_in   (free_idx[g]),
        .tok_out       (tok[g+1]),
        .found_idx_out (found_idx[g+1]),
        .free_idx_out  (free_idx[g+1]),
        .wr            (wr),
        .wr_idx        (wr_idx)
      );
    end
  endgenerate

  // Once the token leaves the last slot it holds the first valid match and the
  // first free slot. The commit logic turns that into a result and at most one
  // slot write, issued in the same cycle the result is loaded.
  always_comb begin
    res_hit    = 1'b0;
    res_mac    = '0;
    res_status = arpc_pkg::ST_OK;
    wr.en      = 1'b0;
    wr.clear   = 1'b0;
    wr.stat    = 1'b0;
    wr.ip      = pend.ip;
    wr.mac     = pend.mac;
    wr_idx     = pend.found ? pend_found_idx : pend_free_idx;
    unique case (pend.op)
      arpc_pkg::OP_LOOKUP: begin
        if (pend.found) begin
          res_hit = 1'b1;
          res_mac = pend.found_mac;
        end else begin
          res_status = arpc_pkg::ST_NOT_FOUND;
        end
      end
      arpc_pkg::OP_INSERT: begin
        if (pend.found && pend.found_static) begin
          res_status = arpc_pkg::ST_WRONG;
        end else if (pend.found || pend.free_found) begin
          wr.en = 1'b1;
        end else begin
          res_status = arpc_pkg::ST_FULL;
        end
      end
      arpc_pkg::OP_ADD: begin
        if (pend.found || pend.free_found) begin
          wr.en   = 1'b1;
          wr.stat = 1'b1;
        end else begin
          res_status = arpc_pkg::ST_FULL;
        end
      end
      arpc_pkg::OP_DELETE: begin
        if (!pend.found) begin
          res_status = arpc_pkg::ST_NOT_FOUND;
        end else if (!pend.found_static) begin
          res_status = arpc_pkg::ST_WRONG;
        end else begin
          wr.en    = 1'b1;
          wr.clear = 1'b1;
        end
      end
      default: begin
        // Flush and tick act on the slots as the token passes; unused codes
        // do nothing. All of them report ok.
      end
    endcase
    wr.en = wr.en && commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
      launch.valid <= 1'b0;
      lifetime     <= arpc_pkg::LIFETIME_RESET;
      now          <= '0;
    end else begin
      if (cfg_valid) begin
        lifetime <= cfg_data;
      end

      launch.valid <= accept;
      if (accept) begin
        busy                <= 1'b1;
        launch.op           <= s_tuser;
        launch.ip           <= s_tdata[31:0];
        launch.mac          <= s_tdata[79:32];
        launch.found        <= 1'b0;
        launch.found_static <= 1'b0;
        launch.found_mac    <= '0;
        launch.free_found   <= 1'b0;
        if (s_tuser == arpc_pkg::OP_TICK) begin
          now <= now + 1'b1;
        end
      end else if (commit) begin
        busy <= 1'b0;
      end

      if (tok[ENTRIES].valid) begin
        pend_valid <= 1'b1;
      end else if (commit) begin
        pend_valid <= 1'b0;
      end

      if (commit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[ENTRIES].valid) begin
      pend           <= tok[ENTRIES];
      pend_found_idx <= found_idx[ENTRIES];
      pend_free_idx  <= free_idx[ENTRIES];
    end
    if (commit) begin
      out_hit    <= res_hit;
      out_mac    <= res_mac;
      out_status <= res_status;
    end
  end

endmodule

### rtl/arpc_checker.sv
// Port-level checks for the ARP cache table, attached by the bind below.
// Depends on arpc_pkg and the port list of arp_cache_table.
module arpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // Only one operation is in flight, so an accepted beat blocks the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an operation was in flight");

  // A hit always reports ok; a miss or non-lookup carries a zero MAC.
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[50:49] == arpc_pkg::ST_OK)
    else $error("hit reported with a non-ok status");

  a_miss_zero_mac: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == '0)
    else $error("miss reported with a nonzero MAC");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/arp_cache_table_tb.sv
// Self-checking testbench for arp_cache_table: operation beats go in, and every result beat
// is checked against an in-bench model of the aging ARP table.
// Depends on arpc_pkg and the arp_cache_table RTL; needs no files or arguments.
`timescale 1ns / 100ps

module arp_cache_table_tb;

  localparam int NSLOT        = arpc_pkg::ENTRIES_DEFAULT;
  localparam int POOL         = 24;        // small address pool so lookups hit and tables fill
  localparam int HOLD_CYCLES  = 300;       // long result stall that backs the block up
  localparam int DRAIN_CYCLES = 2 * (NSLOT + 3);
  localparam int LIMIT_CYCLES = 400000;

  // Operation codes 6 and 7 have no meaning; the block must answer them with status ok.
  localparam logic [arpc_pkg::OP_W-1:0] OP_UNUSED6 = 3'd6;
  localparam logic [arpc_pkg::OP_W-1:0] OP_UNUSED7 = 3'd7;

  typedef enum {STEP_OP, STEP_CFG, STEP_DRAIN, STEP_HOLD, STEP_MODE} plan_kind_t;

  // One entry of the stimulus plan. Only the fields that belong to the kind are used.
  typedef struct {
    plan_kind_t                  kind;
    logic [arpc_pkg::OP_W-1:0]   op;
    logic [arpc_pkg::IP_W-1:0]   ip;
    logic [arpc_pkg::MAC_W-1:0]  mac;
    logic [arpc_pkg::LIFE_W-1:0] life;
    int                          src_pct;
    int                          snk_pct;
  } plan_step_t;

  typedef struct packed {
    logic                          hit;
    logic [arpc_pkg::MAC_W-1:0]    mac;
    logic [arpc_pkg::STATUS_W-1:0] status;
  } arp_reply_t;

  // DUT signals; the inputs are known from time zero.
  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          s_tvalid  = 1'b0;
  logic                          s_tready;
  logic [79:0]                   s_tdata   = '0;   // ip_addr[31:0], mac_addr[79:32]
  logic [arpc_pkg::OP_W-1:0]     s_tuser   = '0;   // operation[2:0]
  logic                          m_tvalid;
  logic                          m_tready  = 1'b0;
  logic [55:0]                   m_tdata;          // hit[0], mac_out[48:1], status[50:49]
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [arpc_pkg::LIFE_W-1:0]   cfg_data  = '0;

  // Table model: per-slot state, the seconds count and the lifetime register.
  logic                        tbl_used   [NSLOT] = '{default: 1'b0};
  logic [arpc_pkg::IP_W-1:0]   tbl_ip     [NSLOT] = '{default: '0};
  logic [arpc_pkg::MAC_W-1:0]  tbl_mac    [NSLOT] = '{default: '0};
  logic                        tbl_static [NSLOT] = '{default: 1'b0};
  logic [arpc_pkg::TIME_W-1:0] tbl_born   [NSLOT] = '{default: '0};
  logic [arpc_pkg::TIME_W-1:0] clock_secs = '0;
  logic [arpc_pkg::LIFE_W-1:0] life_secs  = arpc_pkg::LIFETIME_RESET;

  plan_step_t  plan_q[$];            // stimulus waiting to be driven
  arp_reply_t  pending_replies[$];   // predicted results, oldest first
  logic [arpc_pkg::IP_W-1:0] ip_pool [POOL];

  // Handshake bookkeeping shared between the edge processes.
  logic op_taken  = 1'b0;   // the beat offered in this cycle was taken at the last rising edge
  logic cfg_taken = 1'b0;
  int   src_idle_pct = 14;
  int   snk_idle_pct = 87;
  int   hold_req  = 0;      // bumped by the driver, one long stall per bump
  int   hold_seen = 0;
  int   hold_left = 0;
  int   cycle_cnt = 0;
  int   err_cnt   = 0;

  // Coverage tallies for the closing summary.
  int n_ops = 0, n_hit = 0, n_miss = 0, n_wrong = 0, n_full = 0, n_tick = 0, n_aged = 0;

  arp_cache_table #(.ENTRIES(NSLOT)) u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Table model
  // ---------------------------------------------------------------------------------------

  // A slot is live when it is used and either static or not older than the lifetime.
  // The age is taken modulo 2^32 so the comparison survives a wrap of the seconds count.
  function automatic logic entry_live(input int i);
    logic [arpc_pkg::TIME_W-1:0] age;
    age = clock_secs - tbl_born[i];
    if (!tbl_used[i]) return 1'b0;
    if (tbl_static[i]) return 1'b1;
    return age <= arpc_pkg::TIME_W'(life_secs);
  endfunction

  function automatic int find_live(input logic [arpc_pkg::IP_W-1:0] ip);
    for (int i = 0; i < NSLOT; i++)
      if (entry_live(i) && tbl_ip[i] == ip) return i;
    return -1;
  endfunction

  // Expired and unused slots are both free; the lowest-numbered one is reused first.
  function automatic int find_vacant();
    for (int i = 0; i < NSLOT; i++)
      if (!entry_live(i)) return i;
    return -1;
  endfunction

  function automatic void entry_fill(input int k, input logic [arpc_pkg::IP_W-1:0] ip,
                                     input logic [arpc_pkg::MAC_W-1:0] mac,
                                     input logic stat);
    tbl_used[k]   = 1'b1;
    tbl_ip[k]     = ip;
    tbl_mac[k]    = mac;
    tbl_static[k] = stat;
    tbl_born[k]   = clock_secs;
  endfunction

  // Applies one operation to the table model and returns the result the block must give.
  function automatic arp_reply_t arp_apply(input logic [arpc_pkg::OP_W-1:0] op,
                                           input logic [arpc_pkg::IP_W-1:0] ip,
                                           input logic [arpc_pkg::MAC_W-1:0] mac);
    arp_reply_t r;
    int k;
    r.hit    = 1'b0;
    r.mac    = '0;
    r.status = arpc_pkg::ST_OK;
    n_ops++;
    case (op)
      arpc_pkg::OP_LOOKUP: begin
        k = find_live(ip);
        if (k >= 0) begin
          r.hit = 1'b1;
          r.mac = tbl_mac[k];
        end else begin
          r.status = arpc_pkg::ST_NOT_FOUND;
        end
      end
      arpc_pkg::OP_INSERT: begin
        // A learned address never overrides a static entry, but refreshes a dynamic one.
        k = find_live(ip);
        if (k >= 0) begin
          if (tbl_static[k]) r.status = arpc_pkg::ST_WRONG;
          else entry_fill(k, ip, mac, 1'b0);
        end else begin
          k = find_vacant();
          if (k < 0) r.status = arpc_pkg::ST_FULL;
          else entry_fill(k, ip, mac, 1'b0);
        end
      end
      arpc_pkg::OP_ADD: begin
        k = find_live(ip);
        if (k < 0) k = find_vacant();
        if (k < 0) r.status = arpc_pkg::ST_FULL;
        else entry_fill(k, ip, mac, 1'b1);
      end
      arpc_pkg::OP_DELETE: begin
        k = find_live(ip);
        if (k < 0) r.status = arpc_pkg::ST_NOT_FOUND;
        else if (!tbl_static[k]) r.status = arpc_pkg::ST_WRONG;
        else tbl_used[k] = 1'b0;
      end
      arpc_pkg::OP_FLUSH: begin
        for (int i = 0; i < NSLOT; i++)
          if (!tbl_static[i]) tbl_used[i] = 1'b0;
      end
      arpc_pkg::OP_TICK: begin
        n_tick++;
        clock_secs = clock_secs + 1'b1;
        for (int i = 0; i < NSLOT; i++)
          if (tbl_used[i] && !entry_live(i)) begin
            tbl_used[i] = 1'b0;
            n_aged++;
          end
      end
      default: ;
    endcase
    if (r.hit) n_hit++;
    case (r.status)
      arpc_pkg::ST_NOT_FOUND: n_miss++;
      arpc_pkg::ST_WRONG:     n_wrong++;
      arpc_pkg::ST_FULL:      n_full++;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Plan building
  // ---------------------------------------------------------------------------------------

  function automatic void plan_op(input logic [arpc_pkg::OP_W-1:0] op,
                                  input logic [arpc_pkg::IP_W-1:0] ip,
                                  input logic [arpc_pkg::MAC_W-1:0] mac);
    plan_step_t s;
    s = '{kind: STEP_OP, op: op, ip: ip, mac: mac, life: '0, src_pct: 0, snk_pct: 0};
    plan_q.push_back(s);
  endfunction

  // Lifetime write; the driver holds it back until every predicted result has arrived.
  function automatic void plan_lifetime(input logic [arpc_pkg::LIFE_W-1:0] life);
    plan_step_t s;
    s = '{kind: STEP_CFG, op: '0, ip: '0, mac: '0, life: life, src_pct: 0, snk_pct: 0};
    plan_q.push_back(s);
  endfunction

  function automatic void plan_ctrl(input plan_kind_t kind, input int src_pct,
                                    input int snk_pct);
    plan_step_t s;
    s = '{kind: kind, op: '0, ip: '0, mac: '0, life: '0, src_pct: src_pct, snk_pct: snk_pct};
    plan_q.push_back(s);
  endfunction

  function automatic logic [arpc_pkg::IP_W-1:0] pick_ip();
    if ($urandom_range(99) < 85) return ip_pool[$urandom_range(POOL - 1)];
    return $urandom;
  endfunction

  function automatic logic [arpc_pkg::MAC_W-1:0] pick_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(19))
      0:       return '0;
      1:       return '1;
      default: return w[arpc_pkg::MAC_W-1:0];
    endcase
  endfunction

  // Random operation mix, weighted toward lookups, learning and ticks so entries age out.
  function automatic void plan_random(input int count);
    int roll;
    logic [arpc_pkg::OP_W-1:0] op;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 34)      op = arpc_pkg::OP_LOOKUP;
      else if (roll < 58) op = arpc_pkg::OP_INSERT;
      else if (roll < 64) op = arpc_pkg::OP_ADD;
      else if (roll < 74) op = arpc_pkg::OP_DELETE;
      else if (roll < 76) op = arpc_pkg::OP_FLUSH;
      else if (roll < 97) op = arpc_pkg::OP_TICK;
      else if (roll[0])   op = OP_UNUSED6;
      else                op = OP_UNUSED7;
      plan_op(op, pick_ip(), pick_mac());
    end
  endfunction

  // A burst of fresh addresses that overflows the table, then a static add on a full table.
  function automatic void plan_fill_burst();
    repeat (NSLOT + 4) plan_op(arpc_pkg::OP_INSERT, $urandom, pick_mac());
    plan_op(arpc_pkg::OP_ADD, $urandom, pick_mac());
  endfunction

  // ---------------------------------------------------------------------------------------
  // Driver: offers plan beats at the falling edge. Each valid gets exactly one nonblocking
  // assignment per edge, so a valid that stays high is never dropped and raised again.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    logic valid_n, cfg_n, stepping;
    plan_step_t nxt;
    valid_n  = s_tvalid;
    cfg_n    = cfg_valid;
    stepping = 1'b1;
    if (rst) begin
      valid_n = 1'b0;
      cfg_n   = 1'b0;
    end else if (!((s_tvalid && !op_taken) || (cfg_valid && !cfg_taken))) begin
      // The previous beat, if any, is done; pick the next thing to do.
      valid_n = 1'b0;
      cfg_n   = 1'b0;
      while (stepping && plan_q.size() > 0) begin
        nxt = plan_q[0];
        case (nxt.kind)
          STEP_MODE: begin
            src_idle_pct = nxt.src_pct;
            snk_idle_pct <= nxt.snk_pct;
            void'(plan_q.pop_front());
          end
          STEP_HOLD: begin
            hold_req <= hold_req + 1;
            void'(plan_q.pop_front());
          end
          STEP_DRAIN: begin
            if (pending_replies.size() == 0) void'(plan_q.pop_front());
            else stepping = 1'b0;
          end
          STEP_CFG: begin
            // Every operation yields a result, so an empty expectation queue means idle.
            if (pending_replies.size() == 0) begin
              cfg_n = 1'b1;
              cfg_data <= nxt.life;
              void'(plan_q.pop_front());
            end
            stepping = 1'b0;
          end
          default: begin
            if ($urandom_range(99) >= src_idle_pct) begin
              valid_n = 1'b1;
              s_tuser <= nxt.op;
              s_tdata <= {nxt.mac, nxt.ip};
              void'(plan_q.pop_front());
            end
            stepping = 1'b0;
          end
        endcase
      end
    end
    s_tvalid  <= valid_n;
    cfg_valid <= cfg_n;
  end

  // Receiver: random back-pressure, plus a long stall on request while items keep coming.
  always @(negedge clk) begin
    logic ready_n;
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_n = 1'b0;
    end else begin
      ready_n = $urandom_range(99) >= snk_idle_pct;
    end
    m_tready <= ready_n;
  end

  // ---------------------------------------------------------------------------------------
  // Monitor: at the rising edge, checks result beats, then predicts for accepted inputs.
  // The check runs first so a stray result can never be matched to the beat taken now.
  // ---------------------------------------------------------------------------------------
  function automatic void check_field(input string name,
                                      input logic [arpc_pkg::MAC_W-1:0] want,
                                      input logic [arpc_pkg::MAC_W-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    arp_reply_t want, got;
    if (rst) begin
      op_taken  <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.hit    = m_tdata[0];
        got.mac    = m_tdata[48:1];
        got.status = m_tdata[50:49];
        if (pending_replies.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat with nothing expected, actual hit=%0b mac=%0h status=%0d",
                   $time, got.hit, got.mac, got.status);
        end else begin
          want = pending_replies.pop_front();
          check_field("hit", arpc_pkg::MAC_W'(want.hit), arpc_pkg::MAC_W'(got.hit));
          check_field("mac_out", want.mac, got.mac);
          check_field("status", arpc_pkg::MAC_W'(want.status), arpc_pkg::MAC_W'(got.status));
        end
      end
      if (cfg_valid && cfg_ready) life_secs = cfg_data;
      if (s_tvalid && s_tready)
        pending_replies.push_back(arp_apply(s_tuser, s_tdata[31:0], s_tdata[79:32]));
      op_taken  <= s_tvalid && s_tready;
      cfg_taken <= cfg_valid && cfg_ready;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("%0t: run timed out with %0d plan steps and %0d results outstanding",
               $time, plan_q.size(), pending_replies.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------------------
  initial begin
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < POOL; i++) ip_pool[i] = $urandom;

    // Directed part: sender idles now and then, receiver mostly stalls.
    plan_ctrl(STEP_MODE, 14, 87);
    plan_op(arpc_pkg::OP_LOOKUP, 32'h0, '0);                  // miss on an empty table
    plan_op(arpc_pkg::OP_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    plan_op(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0);
    plan_op(arpc_pkg::OP_INSERT, 32'hFFFF_FFFF, 48'h0);        // refresh a dynamic entry
    plan_op(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '1);
    plan_op(arpc_pkg::OP_ADD,    32'h0, 48'h0123_4567_89AB);
    plan_op(arpc_pkg::OP_INSERT, 32'h0, 48'h1111_2222_3333);   // learning over a static entry
    plan_op(arpc_pkg::OP_ADD,    32'hFFFF_FFFF, 48'hA5A5_5A5A_C3C3); // dynamic turned static
    plan_op(arpc_pkg::OP_DELETE, 32'h0, '0);
    plan_op(arpc_pkg::OP_DELETE, 32'h0, '0);                  // already gone
    plan_op(arpc_pkg::OP_INSERT, 32'h5, 48'h0000_0000_0005);
    plan_op(arpc_pkg::OP_DELETE, 32'h5, '0);                  // delete of a dynamic entry
    plan_op(arpc_pkg::OP_FLUSH,  32'h0, '0);
    plan_op(arpc_pkg::OP_LOOKUP, 32'h5, '0);
    plan_op(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0);          // static survives the flush
    plan_op(OP_UNUSED6, 32'hDEAD_BEEF, '1);
    plan_op(OP_UNUSED7, 32'h1234_5678, 48'h8000_0000_0001);
    // Aging with a one-second lifetime: still valid after one tick, gone after two.
    plan_lifetime(16'd1);
    plan_op(arpc_pkg::OP_INSERT, 32'h0A00_0001, 48'h0200_0000_0001);
    plan_op(arpc_pkg::OP_TICK,   32'h0, '0);
    plan_op(arpc_pkg::OP_LOOKUP, 32'h0A00_0001, '0);
    plan_op(arpc_pkg::OP_TICK,   32'h0, '0);
    plan_op(arpc_pkg::OP_LOOKUP, 32'h0A00_0001, '0);
    plan_op(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0);
    plan_op(arpc_pkg::OP_DELETE, 32'hFFFF_FFFF, '0);

    // Random part, first idling pattern: longest lifetime so the table fills up.
    plan_lifetime('1);
    plan_random(150);
    plan_ctrl(STEP_HOLD, 0, 0);
    plan_random(40);
    plan_op(arpc_pkg::OP_FLUSH, 32'h0, '0);
    plan_lifetime(16'd3);
    plan_random(110);

    // Second idling pattern: zero lifetime, then one second with an overflow burst.
    plan_ctrl(STEP_MODE, 87, 14);
    plan_lifetime(16'd0);
    plan_random(150);
    plan_lifetime(16'd1);
    plan_fill_burst();
    plan_random(100);

    // No idling: stall the receiver while beats keep coming, pause for a full drain, and
    // finish at the longest lifetime again.
    plan_ctrl(STEP_MODE, 0, 0);
    plan_lifetime(16'd5);
    plan_ctrl(STEP_HOLD, 0, 0);
    plan_random(200);
    plan_ctrl(STEP_DRAIN, 0, 0);
    plan_fill_burst();
    plan_lifetime('1);
    plan_random(100);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (plan_q.size() != 0 || s_tvalid || cfg_valid) @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d expected results never arrived", $time, pending_replies.size());
    end

    $display("Ran %0d operations: %0d lookup hits, %0d not found, %0d wrong type, %0d full",
             n_ops, n_hit, n_miss, n_wrong, n_full);
    $display("%0d ticks aged out %0d entries; lifetimes 300, 1, 65535, 3, 0 and 5 were used",
             n_tick, n_aged);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
